// ===== rtl/srf_pkg.sv =====
// Shared types and constants for the sample ring FIFO.
package srf_pkg;

  localparam int SAMPLE_W          = 32;
  localparam int AMT_W             = 7;
  localparam int LEVEL_W           = 13;
  localparam int KIND_W            = 2;
  localparam int DEFAULT_DEPTH     = 4096;
  localparam int DEFAULT_MAX_BURST = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

endpackage

// ===== rtl/srf_ram.sv =====
// Simple dual-port sample memory with one write port and a registered read port.
module srf_ram #(
  parameter int DEPTH  = srf_pkg::DEFAULT_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [srf_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [srf_pkg::SAMPLE_W-1:0] rd_data
);
  import srf_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sample_ring_fifo_core.sv =====
// Sample ring FIFO: circular store of raw 32-bit sample words in one memory.
//
// An item is taken when start is high and busy is low. kind selects the
// operation: write one sample, read a burst, peek the newest burst, or clear.
// Results appear on the result ports for one cycle each, flagged by strobe;
// the receiver must take every result, it cannot hold them off.
//
// Write and clear give one result in the cycle after the item is taken, and
// the next item may be taken in that same cycle, so they run at one item per
// cycle. Read and peek keep busy high until the last of their amount results
// (saturated to MAX_BURST) is out, while the single read port of the sample
// memory fetches the stored words one per cycle; each result follows in the
// cycle after its read, one per cycle. Missing stored samples are padded
// with zero silence.
//
// Reset clears the pointers and the fill count; the memory keeps
// its contents and needs no clearing pass, since only stored entries are read.
module sample_ring_fifo_core #(
  parameter int DEPTH     = srf_pkg::DEFAULT_DEPTH,
  parameter int MAX_BURST = srf_pkg::DEFAULT_MAX_BURST
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [srf_pkg::KIND_W-1:0]   kind,
  input  logic [srf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [srf_pkg::AMT_W-1:0]    amount,
  output logic                         strobe,
  output logic [srf_pkg::SAMPLE_W-1:0] sample_out,
  output logic                         from_store,
  output logic                         accepted,
  output logic                         last,
  output logic [srf_pkg::LEVEL_W-1:0]  level
);
  import srf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int NW = (FW > AMT_W) ? FW : AMT_W;
  localparam int SW = ((PW > NW) ? PW : NW) + 2;

  typedef enum logic {ST_IDLE, ST_BURST} state_t;

  state_t            state;
  logic [PW-1:0]     write_pos;
  logic [PW-1:0]     read_pos;
  logic [FW-1:0]     fill_count;
  logic [PW-1:0]     bptr;
  logic [AMT_W-1:0]  bidx;
  logic [AMT_W-1:0]  bn;
  logic [AMT_W-1:0]  bwant;
  logic              out_from;
  logic              out_acc;

  logic              accept;
  logic              full;
  logic [AMT_W-1:0]  want_c;
  logic [NW-1:0]     n_c;
  logic [SW-1:0]     peek_sum;
  logic [SW-1:0]     read_sum;
  logic [PW-1:0]     peek_start;
  logic [PW-1:0]     read_pos_next;
  logic [PW-1:0]     write_pos_next;
  logic [PW-1:0]     bptr_next;
  logic              wr_en;
  logic              rd_en;
  logic              burst_last;
  logic [SAMPLE_W-1:0] rd_data;
  logic [FW+LEVEL_W-1:0] fill_ext;

  assign busy   = (state == ST_BURST);
  assign accept = start && !busy;
  assign full   = (fill_count == FW'(DEPTH));

  assign want_c = (amount > AMT_W'(MAX_BURST)) ? AMT_W'(MAX_BURST) : amount;
  assign n_c    = (NW'(want_c) < NW'(fill_count)) ? NW'(want_c) : NW'(fill_count);

  // Both sums stay below twice the depth, so one conditional subtract wraps them.
  assign peek_sum   = SW'(read_pos) + SW'(fill_count) - SW'(n_c);
  assign read_sum   = SW'(read_pos) + SW'(n_c);
  assign peek_start = (peek_sum >= SW'(DEPTH)) ? PW'(peek_sum - SW'(DEPTH)) : PW'(peek_sum);
  assign read_pos_next = (read_sum >= SW'(DEPTH)) ? PW'(read_sum - SW'(DEPTH))
                                                  : PW'(read_sum);
  assign write_pos_next = (write_pos == PW'(DEPTH - 1)) ? '0 : write_pos + 1'b1;
  assign bptr_next      = (bptr == PW'(DEPTH - 1)) ? '0 : bptr + 1'b1;

  assign wr_en      = accept && (kind == KIND_WRITE) && !full;
  assign rd_en      = busy && (bidx < bn);
  assign burst_last = (bidx == bwant - 1'b1);

  srf_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_pos),
    .wr_data (sample_in),
    .rd_en   (rd_en),
    .rd_addr (bptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_pos  <= '0;
      read_pos   <= '0;
      fill_count <= '0;
      strobe     <= 1'b0;
      out_from   <= 1'b0;
      out_acc    <= 1'b0;
      last       <= 1'b0;
      bptr       <= '0;
      bidx       <= '0;
      bn         <= '0;
      bwant      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          strobe   <= 1'b0;
          out_from <= 1'b0;
          out_acc  <= 1'b0;
          last     <= 1'b0;
          if (accept) begin
            case (kind)
              KIND_WRITE: begin
                strobe  <= 1'b1;
                last    <= 1'b1;
                out_acc <= !full;
                if (!full) begin
                  write_pos  <= write_pos_next;
                  fill_count <= fill_count + 1'b1;
                end
              end
              KIND_CLEAR: begin
                strobe     <= 1'b1;
                last       <= 1'b1;
                write_pos  <= '0;
                read_pos   <= '0;
                fill_count <= '0;
              end
              KIND_READ, KIND_PEEK: begin
                // A zero-length request produces nothing and leaves the state alone.
                if (want_c != '0) begin
                  state <= ST_BURST;
                  bidx  <= '0;
                  bn    <= AMT_W'(n_c);
                  bwant <= want_c;
                  if (kind == KIND_READ) begin
                    bptr       <= read_pos;
                    read_pos   <= read_pos_next;
                    fill_count <= fill_count - FW'(n_c);
                  end else begin
                    bptr <= peek_start;
                  end
                end
              end
              default: begin
                strobe <= 1'b0;
              end
            endcase
          end
        end
        ST_BURST: begin
          strobe   <= 1'b1;
          out_from <= (bidx < bn);
          out_acc  <= 1'b0;
          last     <= burst_last;
          bidx     <= bidx + 1'b1;
          bptr     <= bptr_next;
          if (burst_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign fill_ext   = {{LEVEL_W{1'b0}}, fill_count};
  assign level      = fill_ext[LEVEL_W-1:0];
  assign sample_out = out_from ? rd_data : '0;
  assign from_store = out_from;
  assign accepted   = out_acc;

endmodule

// ===== rtl/srf_check.sv =====
// Port-level checks for the sample ring FIFO, bound to the top level.
module srf_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [srf_pkg::KIND_W-1:0]   kind,
  input logic [srf_pkg::AMT_W-1:0]    amount,
  input logic                         strobe,
  input logic [srf_pkg::SAMPLE_W-1:0] sample_out,
  input logic                         from_store,
  input logic                         accepted,
  input logic                         last,
  input logic [srf_pkg::LEVEL_W-1:0]  level
);
  import srf_pkg::*;

  // A burst request holds off further items while it is fetched.
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_READ || kind == KIND_PEEK) && amount != '0)
    |=> busy)
    else $error("burst item did not raise busy");

  // Write and clear each give exactly one result in the next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_WRITE || kind == KIND_CLEAR))
    |=> (strobe && last))
    else $error("write or clear result missing");

  a_clear_level: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_CLEAR) |=> (level == '0))
    else $error("level not zero after clear");

  a_silence_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !from_store) |-> (sample_out == '0))
    else $error("silence item carries a nonzero sample");

  a_accept_only_write: assert property (@(posedge clk) disable iff (rst)
    (strobe && accepted) |-> (!from_store && last))
    else $error("accepted flag on a burst result");

endmodule

bind sample_ring_fifo_core srf_check u_srf_check (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .kind       (kind),
  .amount     (amount),
  .strobe     (strobe),
  .sample_out (sample_out),
  .from_store (from_store),
  .accepted   (accepted),
  .last       (last),
  .level      (level)
);
